[rtl/nll_pkg.sv]
// Package for the node language lexer: transfer payload types, token kind
// codes, scan modes, the keyword table and byte classification functions.
// No dependencies.
package nll_pkg;

  // Default and output widths of byte positions.
  localparam int PosWidthDef = 16;
  localparam int PosOutW     = 16;

  // Token kinds as they appear on the output.
  typedef enum logic [4:0] {
    KIND_STRING   = 5'd0,
    KIND_CODE     = 5'd1,
    KIND_LBRACKET = 5'd2,
    KIND_RBRACKET = 5'd3,
    KIND_LBRACE   = 5'd4,
    KIND_RBRACE   = 5'd5,
    KIND_KW_NODE  = 5'd6,
    KIND_IDENT    = 5'd14,
    KIND_TAG      = 5'd15,
    KIND_EVENT    = 5'd16
  } token_kind_e;

  // Scanner modes.
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_STRING = 3'd1,
    MODE_CODE   = 3'd2,
    MODE_WORD   = 3'd3,
    MODE_TAGPRE = 3'd4,
    MODE_TAG    = 3'd5,
    MODE_EVPRE  = 3'd6,
    MODE_EVENT  = 3'd7
  } scan_mode_e;

  // Input item: one text byte.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_last;
  } nll_in_t;

  // Result item: one token.
  typedef struct packed {
    logic [4:0]         token_kind;
    logic [PosOutW-1:0] start_pos;
    logic [PosOutW-1:0] end_pos;
    logic               last_of_run;
  } nll_tok_t;

  // Special characters.
  localparam logic [7:0] ChQuote    = 8'h22;
  localparam logic [7:0] ChTick     = 8'h60;
  localparam logic [7:0] ChLBracket = 8'h5B;
  localparam logic [7:0] ChRBracket = 8'h5D;
  localparam logic [7:0] ChLBrace   = 8'h7B;
  localparam logic [7:0] ChRBrace   = 8'h7D;
  localparam logic [7:0] ChAt       = 8'h40;
  localparam logic [7:0] ChBang     = 8'h21;

  // Keyword table: node, as, in, out, on, include, partial, extends.
  localparam int NumKw = 8;
  localparam logic [7:0] KwText [NumKw][8] = '{
    '{"n", "o", "d", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"a", "s", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"o", "u", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"o", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "n", "c", "l", "u", "d", "e", 8'h00},
    '{"p", "a", "r", "t", "i", "a", "l", 8'h00},
    '{"e", "x", "t", "e", "n", "d", "s", 8'h00}
  };
  localparam logic [3:0] KwLen [NumKw] = '{
    4'd4, 4'd2, 4'd2, 4'd3, 4'd2, 4'd7, 4'd7, 4'd7
  };

  // Letters, digits and underscore are word bytes.
  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
           is_digit(c) || (c == "_");
  endfunction

  function automatic logic is_word_start(logic [7:0] c);
    return is_word(c) && !is_digit(c);
  endfunction

  // Drop every keyword that does not continue with this byte.
  function automatic logic [NumKw-1:0] kw_take(logic [NumKw-1:0] alive,
                                              logic [3:0] len,
                                              logic [7:0] c);
    logic [NumKw-1:0] res;
    res = alive;
    for (int k = 0; k < NumKw; k++) begin
      if ((len >= KwLen[k]) || (KwText[k][len[2:0]] != c)) begin
        res[k] = 1'b0;
      end
    end
    return res;
  endfunction

  // Kind of a finished word: the first keyword still alive at full length.
  function automatic logic [4:0] word_kind(logic [NumKw-1:0] alive,
                                          logic [3:0] len);
    logic [4:0] res;
    res = KIND_IDENT;
    for (int k = NumKw - 1; k >= 0; k--) begin
      if (alive[k] && (len == KwLen[k])) begin
        res = KIND_KW_NODE + 5'(k);
      end
    end
    return res;
  endfunction

endpackage

[rtl/node_language_lexer_unit.sv]
// Top level of the node language lexer: byte scanner and token queue.
// Depends on nll_pkg.
//
// The lexer takes one text byte per transfer and emits the tokens that the
// byte completes, each as a kind with inclusive start and end positions.
// A byte is taken in a cycle in which it is not stalled; its tokens (none,
// one or two) are written into a four-entry queue in the same edge, and the
// queue hands out one token per cycle unless the output stalls. Bytes flow
// at one per cycle as long as the queue has room for two tokens; a byte that
// closes two tokens adds two to the queue, so a run of them stalls input.
// Positions count from zero after reset and after each last byte, saturate
// at the all-ones value of POS_WIDTH, and leave the block as 16 bits.
module node_language_lexer_unit
  import nll_pkg::*;
#(
  parameter int POS_WIDTH = PosWidthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  nll_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output nll_tok_t out_data_o
);

  localparam int ExtW  = (POS_WIDTH > PosOutW) ? POS_WIDTH : PosOutW;
  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  typedef logic [POS_WIDTH-1:0] pos_t;

  // Scanner state.
  scan_mode_e       mode_q, mode_d;
  pos_t             pos_q, pos_d;
  pos_t             last_q, last_d;
  pos_t             start_q, start_d;
  logic [3:0]       len_q, len_d;
  logic [NumKw-1:0] alive_q, alive_d;

  // Token queue.
  nll_tok_t        fifo_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q, cnt_d;

  logic       in_xfer, out_xfer;
  logic [7:0] c;
  logic       redo;
  logic       v0, v1, v2;
  logic [4:0] k0, k1, k2;
  pos_t       s0, e0, s1, s2;
  nll_tok_t   tok_a, tok_b;
  logic [1:0] n_tok;

  function automatic logic [PosOutW-1:0] out_pos(pos_t p);
    logic [ExtW-1:0] ext;
    ext = ExtW'(p);
    return ext[PosOutW-1:0];
  endfunction

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;
  assign c        = in_data_i.text_byte;

  // Next scanner state and the tokens this byte completes.
  always_comb begin
    mode_d  = mode_q;
    start_d = start_q;
    len_d   = len_q;
    alive_d = alive_q;
    pos_d   = pos_q;
    last_d  = last_q;
    redo    = 1'b0;
    v0 = 1'b0; v1 = 1'b0; v2 = 1'b0;
    k0 = KIND_IDENT; k1 = KIND_IDENT; k2 = KIND_IDENT;
    s0 = start_q; e0 = pos_q; s1 = pos_q; s2 = start_q;

    // Continue the open token.
    unique case (mode_q) inside
      MODE_STRING, MODE_CODE: begin
        if (c == ((mode_q == MODE_STRING) ? ChQuote : ChTick)) begin
          v0     = 1'b1;
          k0     = (mode_q == MODE_STRING) ? KIND_STRING : KIND_CODE;
          mode_d = MODE_IDLE;
        end
      end
      MODE_WORD: begin
        if (is_word(c)) begin
          alive_d = kw_take(alive_q, len_q, c);
          len_d   = (len_q == 4'hF) ? len_q : len_q + 4'd1;
        end else begin
          v0     = 1'b1;
          k0     = word_kind(alive_q, len_q);
          e0     = last_q;
          mode_d = MODE_IDLE;
          redo   = 1'b1;
        end
      end
      MODE_TAGPRE, MODE_EVPRE: begin
        if (is_word(c)) begin
          mode_d = (mode_q == MODE_TAGPRE) ? MODE_TAG : MODE_EVENT;
        end else begin
          mode_d = MODE_IDLE;
          redo   = 1'b1;
        end
      end
      MODE_TAG, MODE_EVENT: begin
        if (!is_word(c)) begin
          v0     = 1'b1;
          k0     = (mode_q == MODE_TAG) ? KIND_TAG : KIND_EVENT;
          e0     = last_q;
          mode_d = MODE_IDLE;
          redo   = 1'b1;
        end
      end
      default: begin
        mode_d = MODE_IDLE;
        redo   = 1'b1;
      end
    endcase

    // Lex the byte from idle.
    if (redo) begin
      case (c)
        ChQuote: begin
          mode_d  = MODE_STRING;
          start_d = pos_q;
        end
        ChTick: begin
          mode_d  = MODE_CODE;
          start_d = pos_q;
        end
        ChLBracket: begin
          v1 = 1'b1;
          k1 = KIND_LBRACKET;
        end
        ChRBracket: begin
          v1 = 1'b1;
          k1 = KIND_RBRACKET;
        end
        ChLBrace: begin
          v1 = 1'b1;
          k1 = KIND_LBRACE;
        end
        ChRBrace: begin
          v1 = 1'b1;
          k1 = KIND_RBRACE;
        end
        ChAt: begin
          mode_d  = MODE_TAGPRE;
          start_d = pos_q;
        end
        ChBang: begin
          mode_d  = MODE_EVPRE;
          start_d = pos_q;
        end
        default: begin
          if (is_word_start(c)) begin
            mode_d  = MODE_WORD;
            start_d = pos_q;
            alive_d = kw_take('1, 4'd0, c);
            len_d   = 4'd1;
          end
        end
      endcase
    end

    // End of text: flush an open word, tag or event, then start over.
    if (in_data_i.is_last) begin
      s2 = start_d;
      case (mode_d)
        MODE_WORD: begin
          v2 = 1'b1;
          k2 = word_kind(alive_d, len_d);
        end
        MODE_TAG: begin
          v2 = 1'b1;
          k2 = KIND_TAG;
        end
        MODE_EVENT: begin
          v2 = 1'b1;
          k2 = KIND_EVENT;
        end
        default: ;
      endcase
      mode_d  = MODE_IDLE;
      pos_d   = '0;
      last_d  = '0;
      start_d = '0;
      len_d   = '0;
      alive_d = '1;
    end else begin
      last_d = pos_q;
      pos_d  = (pos_q == '1) ? pos_q : pos_q + pos_t'(1);
    end
  end

  // Pack the completed tokens in order; at most two are ever present.
  always_comb begin
    tok_a = '0;
    tok_b = '0;
    if (v0) begin
      tok_a.token_kind = k0;
      tok_a.start_pos  = out_pos(s0);
      tok_a.end_pos    = out_pos(e0);
      if (v1) begin
        tok_b.token_kind = k1;
        tok_b.start_pos  = out_pos(s1);
        tok_b.end_pos    = out_pos(s1);
      end else begin
        tok_b.token_kind = k2;
        tok_b.start_pos  = out_pos(s2);
        tok_b.end_pos    = out_pos(pos_q);
      end
    end else if (v1) begin
      tok_a.token_kind = k1;
      tok_a.start_pos  = out_pos(s1);
      tok_a.end_pos    = out_pos(s1);
    end else begin
      tok_a.token_kind = k2;
      tok_a.start_pos  = out_pos(s2);
      tok_a.end_pos    = out_pos(pos_q);
    end
    n_tok = 2'({1'b0, v0}) + 2'({1'b0, v1}) + 2'({1'b0, v2});
    tok_a.last_of_run = (n_tok == 2'd1);
    tok_b.last_of_run = 1'b1;
  end

  // Queue occupancy.
  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer) begin
      cnt_d = cnt_d + (PtrW+1)'(n_tok);
    end
    if (out_xfer) begin
      cnt_d = cnt_d - (PtrW+1)'(1);
    end
  end

  assign in_stall_o  = (cnt_q > (PtrW+1)'(Depth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = fifo_q[rd_q];

  // Scanner and queue control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      last_q  <= '0;
      start_q <= '0;
      len_q   <= '0;
      alive_q <= '1;
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
    end else begin
      if (in_xfer) begin
        mode_q  <= mode_d;
        pos_q   <= pos_d;
        last_q  <= last_d;
        start_q <= start_d;
        len_q   <= len_d;
        alive_q <= alive_d;
        wr_q    <= wr_q + PtrW'(n_tok);
      end
      if (out_xfer) begin
        rd_q <= rd_q + PtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (in_xfer && (n_tok != 2'd0)) begin
      fifo_q[wr_q] <= tok_a;
    end
    if (in_xfer && (n_tok == 2'd2)) begin
      fifo_q[wr_q + PtrW'(1)] <= tok_b;
    end
  end

endmodule
